// File: hw/rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and helpers for the Playfair digraph cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfc_pkg;

  localparam int unsigned SQUARE_SIDE = 5;
  localparam int unsigned CELLS       = SQUARE_SIDE * SQUARE_SIDE;
  localparam int unsigned LETTERS     = 26;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned RC_W        = 3;

  localparam logic [IDX_W-1:0] IDX_I = 5'd8;
  localparam logic [IDX_W-1:0] IDX_J = 5'd9;

  localparam logic [7:0] ASCII_UP_A = 8'h41;
  localparam logic [7:0] ASCII_UP_Z = 8'h5A;
  localparam logic [7:0] ASCII_LO_A = 8'h61;
  localparam logic [7:0] ASCII_LO_Z = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  typedef enum logic [2:0] {
    CMD_START_KEY  = 3'd0,
    CMD_KEY_LETTER = 3'd1,
    CMD_FINISH_KEY = 3'd2,
    CMD_ENCIPHER   = 3'd3,
    CMD_DECIPHER   = 3'd4
  } command_e;

  typedef enum logic [1:0] {
    STAT_OK            = 2'd0,
    STAT_NOT_IN_SQUARE = 2'd1,
    STAT_WRONG_PHASE   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_FIN_OUT,
    S_LOOK_A,
    S_LOOK_B,
    S_CALC,
    S_SQ_A,
    S_SQ_B,
    S_SQ_C
  } seq_state_e;

  typedef struct packed {
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
  } pos_t;

  typedef struct packed {
    logic [IDX_W-1:0] cell1;
    logic [IDX_W-1:0] cell2;
  } pair_cells_t;

  function automatic logic is_upper(input logic [7:0] ch);
    return (ch >= ASCII_UP_A) && (ch <= ASCII_UP_Z);
  endfunction

  // upper-case letter to index, J folded onto I
  function automatic logic [IDX_W-1:0] fold_index(input logic [7:0] ch);
    logic [7:0] diff;
    diff = ch - ASCII_UP_A;
    if (diff[IDX_W-1:0] == IDX_J) begin
      return IDX_I;
    end
    return diff[IDX_W-1:0];
  endfunction

  function automatic pos_t split_pos(input logic [IDX_W-1:0] cell_idx);
    pos_t p;
    logic [IDX_W-1:0] rem;
    if (cell_idx >= IDX_W'(4 * SQUARE_SIDE)) begin
      p.row = RC_W'(4);
      rem   = cell_idx - IDX_W'(4 * SQUARE_SIDE);
    end else if (cell_idx >= IDX_W'(3 * SQUARE_SIDE)) begin
      p.row = RC_W'(3);
      rem   = cell_idx - IDX_W'(3 * SQUARE_SIDE);
    end else if (cell_idx >= IDX_W'(2 * SQUARE_SIDE)) begin
      p.row = RC_W'(2);
      rem   = cell_idx - IDX_W'(2 * SQUARE_SIDE);
    end else if (cell_idx >= IDX_W'(SQUARE_SIDE)) begin
      p.row = RC_W'(1);
      rem   = cell_idx - IDX_W'(SQUARE_SIDE);
    end else begin
      p.row = RC_W'(0);
      rem   = cell_idx;
    end
    p.col = rem[RC_W-1:0];
    return p;
  endfunction

  function automatic logic [IDX_W-1:0] join_pos(input pos_t p);
    return (IDX_W'(p.row) << 2) + IDX_W'(p.row) + IDX_W'(p.col);
  endfunction

  function automatic logic [RC_W-1:0] step_rc(input logic [RC_W-1:0] v,
                                              input logic             back);
    if (back) begin
      return (v == '0) ? RC_W'(SQUARE_SIDE - 1) : v - RC_W'(1);
    end
    return (v == RC_W'(SQUARE_SIDE - 1)) ? '0 : v + RC_W'(1);
  endfunction

endpackage

// File: hw/rtl/pfc_ram.sv
// ----------------------------------------------------------------------------
// pfc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfc_ram #(
  parameter int unsigned  WIDTH  = 8,
  parameter int unsigned  DEPTH  = 32,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/pfc_grid.sv
// ----------------------------------------------------------------------------
// pfc_grid
// Digraph rule unit: maps two square positions to the two target cells
// using the row, column or rectangle rule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfc_grid
  import pfc_pkg::*;
(
  input  logic [IDX_W-1:0] p1_i,
  input  logic [IDX_W-1:0] p2_i,
  input  logic             decipher_i,
  output pair_cells_t      cells_o
);

  pos_t pa, pb, ta, tb;

  always_comb begin
    pa = split_pos(p1_i);
    pb = split_pos(p2_i);
    ta = pa;
    tb = pb;
    priority if (pa.row == pb.row) begin
      ta.col = step_rc(pa.col, decipher_i);
      tb.col = step_rc(pb.col, decipher_i);
    end else if (pa.col == pb.col) begin
      ta.row = step_rc(pa.row, decipher_i);
      tb.row = step_rc(pb.row, decipher_i);
    end else begin
      ta.col = pb.col;
      tb.col = pa.col;
    end
    cells_o.cell1 = join_pos(ta);
    cells_o.cell2 = join_pos(tb);
  end

endmodule

// File: hw/rtl/playfair_digraph_cipher_top.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_top
// Sequence: start key and key letter are answered from idle; finish key walks
//   the letters A..Z through the placement logic; a cipher pair takes two cell
//   RAM reads, the rule unit and two square RAM reads; errors answer from idle.
// Throughput: one transaction at a time; stall is held until the result is
//   registered. Reset clears the used flags, fill count and ready flag; the
//   square RAMs are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module playfair_digraph_cipher_top
  import pfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] command_i,
  input  logic [7:0] first_char_i,
  input  logic [7:0] second_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] first_out_o,
  output logic [7:0] second_out_o,
  output logic [1:0] status_o
);

  seq_state_e state_q, state_d;

  logic [LETTERS-1:0] used_q;
  logic [IDX_W-1:0]   fill_q;
  logic               ready_q;
  logic [IDX_W-1:0]   walk_q;
  logic [IDX_W-1:0]   idx_a_q, idx_b_q;
  logic               dec_q;
  logic [IDX_W-1:0]   p1_q;
  pair_cells_t        cells_q;
  logic [IDX_W-1:0]   let1_q;

  logic       out_valid_q;
  logic [7:0] out_first_q, out_second_q;
  status_e    out_status_q;

  logic       out_free, in_accept;
  logic [7:0] key_up;
  logic       key_ok, a_ok, b_ok;
  logic [IDX_W-1:0] key_idx;

  logic             place_req, place_en;
  logic [IDX_W-1:0] place_idx;
  logic             cell_rd_en, sq_rd_en;
  logic [IDX_W-1:0] cell_rd_addr, sq_rd_addr;
  logic [IDX_W-1:0] cell_rd_data, sq_rd_data;
  pair_cells_t      cells_calc;

  logic       out_load;
  logic [7:0] out_first_d, out_second_d;
  status_e    out_status_d;
  logic       used_clear, ready_set, pair_load, walk_start;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    key_up  = ((first_char_i >= ASCII_LO_A) && (first_char_i <= ASCII_LO_Z)) ?
              first_char_i - CASE_DIFF : first_char_i;
    key_ok  = is_upper(key_up);
    key_idx = fold_index(key_up);
    a_ok    = is_upper(first_char_i);
    b_ok    = is_upper(second_char_i);
  end

  assign place_en = place_req && !used_q[place_idx] && (fill_q < IDX_W'(CELLS));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          unique case (command_i)
            CMD_FINISH_KEY: if (!ready_q) state_d = S_FILL;
            CMD_ENCIPHER, CMD_DECIPHER: begin
              if (ready_q && a_ok && b_ok) state_d = S_LOOK_A;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_FILL:    if (walk_q == IDX_W'(LETTERS - 1)) state_d = S_FIN_OUT;
      S_FIN_OUT: if (out_free) state_d = S_IDLE;
      S_LOOK_A:  state_d = S_LOOK_B;
      S_LOOK_B:  state_d = S_CALC;
      S_CALC:    state_d = S_SQ_A;
      S_SQ_A:    state_d = S_SQ_B;
      S_SQ_B:    state_d = S_SQ_C;
      S_SQ_C:    if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    place_req    = 1'b0;
    place_idx    = key_idx;
    cell_rd_en   = 1'b0;
    cell_rd_addr = idx_a_q;
    sq_rd_en     = 1'b0;
    sq_rd_addr   = cells_q.cell1;
    out_load     = 1'b0;
    out_first_d  = '0;
    out_second_d = '0;
    out_status_d = STAT_OK;
    used_clear   = 1'b0;
    ready_set    = 1'b0;
    pair_load    = 1'b0;
    walk_start   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          unique case (command_i)
            CMD_START_KEY: begin
              used_clear = 1'b1;
              out_load   = 1'b1;
            end
            CMD_KEY_LETTER: begin
              out_load = 1'b1;
              if (ready_q) begin
                out_status_d = STAT_WRONG_PHASE;
              end else begin
                place_req = key_ok;
              end
            end
            CMD_FINISH_KEY: begin
              walk_start = 1'b1;
              out_load   = ready_q;
            end
            CMD_ENCIPHER, CMD_DECIPHER: begin
              pair_load    = 1'b1;
              out_first_d  = first_char_i;
              out_second_d = second_char_i;
              if (!ready_q) begin
                out_load     = 1'b1;
                out_status_d = STAT_WRONG_PHASE;
              end else if (!(a_ok && b_ok)) begin
                out_load     = 1'b1;
                out_status_d = STAT_NOT_IN_SQUARE;
              end
            end
            default: begin
              out_load     = 1'b1;
              out_status_d = STAT_WRONG_PHASE;
            end
          endcase
        end
      end
      S_FILL: begin
        place_idx = walk_q;
        place_req = (walk_q != IDX_J);
      end
      S_FIN_OUT: begin
        ready_set = 1'b1;
        out_load  = out_free;
      end
      S_LOOK_A: begin
        cell_rd_en   = 1'b1;
        cell_rd_addr = idx_a_q;
      end
      S_LOOK_B: begin
        cell_rd_en   = 1'b1;
        cell_rd_addr = idx_b_q;
      end
      S_CALC: ;
      S_SQ_A: begin
        sq_rd_en   = 1'b1;
        sq_rd_addr = cells_q.cell1;
      end
      S_SQ_B: begin
        sq_rd_en   = 1'b1;
        sq_rd_addr = cells_q.cell2;
      end
      S_SQ_C: begin
        out_load     = out_free;
        out_first_d  = ASCII_UP_A + {3'b000, let1_q};
        out_second_d = ASCII_UP_A + {3'b000, sq_rd_data};
      end
      default: ;
    endcase
  end

  pfc_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CELLS)
  ) u_square_ram (
    .clk_i     (clk_i),
    .wr_en_i   (place_en),
    .wr_addr_i (fill_q),
    .wr_data_i (place_idx),
    .rd_en_i   (sq_rd_en),
    .rd_addr_i (sq_rd_addr),
    .rd_data_o (sq_rd_data)
  );

  pfc_ram #(
    .WIDTH (IDX_W),
    .DEPTH (LETTERS)
  ) u_cell_ram (
    .clk_i     (clk_i),
    .wr_en_i   (place_en),
    .wr_addr_i (place_idx),
    .wr_data_i (fill_q),
    .rd_en_i   (cell_rd_en),
    .rd_addr_i (cell_rd_addr),
    .rd_data_o (cell_rd_data)
  );

  pfc_grid u_grid (
    .p1_i       (p1_q),
    .p2_i       (cell_rd_data),
    .decipher_i (dec_q),
    .cells_o    (cells_calc)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      fill_q      <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (used_clear) begin
        used_q  <= '0;
        fill_q  <= '0;
        ready_q <= 1'b0;
      end else begin
        if (place_en) begin
          used_q[place_idx] <= 1'b1;
          fill_q            <= fill_q + IDX_W'(1);
        end
        if (ready_set) begin
          ready_q <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (walk_start) begin
      walk_q <= '0;
    end else if (state_q == S_FILL) begin
      walk_q <= walk_q + IDX_W'(1);
    end
    if (pair_load) begin
      idx_a_q <= fold_index(first_char_i);
      idx_b_q <= fold_index(second_char_i);
      dec_q   <= (command_i == CMD_DECIPHER);
    end
    if (state_q == S_LOOK_B) begin
      p1_q <= cell_rd_data;
    end
    if (state_q == S_CALC) begin
      cells_q <= cells_calc;
    end
    if (state_q == S_SQ_B) begin
      let1_q <= sq_rd_data;
    end
    if (out_load) begin
      out_first_q  <= out_first_d;
      out_second_q <= out_second_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign first_out_o  = out_first_q;
  assign second_out_o = out_second_q;
  assign status_o     = out_status_q;

endmodule
